FILE: src/sglf_pkg.sv
// Package for the separable Gaussian line filter.
// Holds the default sizes, the field widths, the codes and the job type.
// No dependencies.
package sglf_pkg;

  localparam int unsigned MaxTapsDefault    = 31;
  localparam int unsigned WeightBitsDefault = 16;

  localparam int unsigned HalfWidthBits = 4;
  localparam int unsigned TapIndexBits  = 5;
  localparam int unsigned TapWeightBits = 16;
  localparam int unsigned CompBits      = 8;
  localparam int unsigned CountBits     = 5;
  localparam int unsigned PixelBits     = 4 * CompBits;

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [HalfWidthBits-1:0] HalfWidthReset = 4'd1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef struct packed {
    logic [HalfWidthBits-1:0] offset;
    logic [CountBits-1:0]     count;
    logic                     last;
  } job_t;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
    logic [CompBits-1:0] alpha;
    logic                done;
  } result_t;

endpackage

FILE: src/sglf_fifo.sv
// Small first-in first-out queue used between the stages of the filter.
// Depends on nothing; the depth must be a power of two.
module sglf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem [DEPTH];
  logic [PtrBits-1:0] wp_q, rp_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_wr, do_rd;

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/sglf_front.sv
// Front end of the filter: takes words, stores taps and the pixel window,
// and issues one job per result into the job queue. Uses sglf_pkg.
module sglf_front #(
  parameter int unsigned MAX_TAPS    = sglf_pkg::MaxTapsDefault,
  parameter int unsigned WEIGHT_BITS = sglf_pkg::WeightBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [sglf_pkg::HalfWidthBits-1:0]   half_width_i,
  input  logic                                 accept_i,
  input  logic                                 operation_i,
  input  logic [sglf_pkg::TapIndexBits-1:0]    tap_index_i,
  input  logic [sglf_pkg::TapWeightBits-1:0]   tap_weight_i,
  input  logic [sglf_pkg::PixelBits-1:0]       pixel_i,
  input  logic                                 line_end_i,
  input  logic                                 jq_full_i,
  input  logic                                 jq_empty_i,
  input  logic                                 back_busy_i,
  output logic                                 jq_wr_o,
  output sglf_pkg::job_t                       job_o,
  output logic                                 busy_o,
  output logic [sglf_pkg::PixelBits-1:0]       window_o [MAX_TAPS],
  output logic [WEIGHT_BITS-1:0]               taps_o [MAX_TAPS]
);

  localparam int unsigned IdxBits = $clog2(MAX_TAPS);

  logic [sglf_pkg::PixelBits-1:0]     win_q [MAX_TAPS];
  logic [WEIGHT_BITS-1:0]             tap_q [MAX_TAPS];
  logic [sglf_pkg::CountBits-1:0]     count_q, count_d, jcnt_q;
  logic [sglf_pkg::HalfWidthBits-1:0] dist_q, lo_q;
  logic                               gen_q, last_q, busy_q;
  logic                               take_pixel, take_load, want_job, advance;

  assign take_pixel = accept_i && (operation_i == sglf_pkg::OP_PIXEL);
  assign take_load  = accept_i && (operation_i == sglf_pkg::OP_LOAD);
  assign count_d    = (count_q == sglf_pkg::CountMax) ? count_q : count_q + 1'b1;
  assign want_job   = gen_q && ({1'b0, dist_q} < jcnt_q);
  assign advance    = gen_q && !(want_job && jq_full_i);

  assign jq_wr_o      = want_job && !jq_full_i;
  assign job_o.offset = dist_q;
  assign job_o.count  = jcnt_q;
  assign job_o.last   = last_q && (dist_q == '0);
  assign busy_o       = busy_q;
  assign window_o     = win_q;
  assign taps_o       = tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        win_q[k] <= '0;
        tap_q[k] <= '0;
      end
      count_q <= '0;
      jcnt_q  <= '0;
      dist_q  <= '0;
      lo_q    <= '0;
      gen_q   <= 1'b0;
      last_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      if (take_load && ({1'b0, tap_index_i} < 6'(MAX_TAPS))) begin
        tap_q[IdxBits'(tap_index_i)] <= WEIGHT_BITS'(tap_weight_i);
      end
      if (take_pixel) begin
        for (int k = MAX_TAPS - 1; k > 0; k--) begin
          win_q[k] <= win_q[k-1];
        end
        win_q[0] <= pixel_i;
        jcnt_q   <= count_d;
        count_q  <= line_end_i ? '0 : count_d;
        dist_q   <= half_width_i;
        lo_q     <= line_end_i ? '0 : half_width_i;
        last_q   <= line_end_i;
        gen_q    <= 1'b1;
      end else if (advance) begin
        if (dist_q == lo_q) begin
          gen_q <= 1'b0;
        end else begin
          dist_q <= dist_q - 1'b1;
        end
      end
      busy_q <= take_pixel || gen_q || !jq_empty_i || back_busy_i;
    end
  end

endmodule

FILE: src/sglf_back.sv
// Back end of the filter: one multiply-accumulate pass over the kernel per
// job, then rounding and saturation into the result queue. Uses sglf_pkg.
module sglf_back #(
  parameter int unsigned MAX_TAPS    = sglf_pkg::MaxTapsDefault,
  parameter int unsigned WEIGHT_BITS = sglf_pkg::WeightBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sglf_pkg::HalfWidthBits-1:0] half_width_i,
  input  logic                               jq_empty_i,
  input  sglf_pkg::job_t                     job_i,
  output logic                               jq_rd_o,
  input  logic [sglf_pkg::PixelBits-1:0]     window_i [MAX_TAPS],
  input  logic [WEIGHT_BITS-1:0]             taps_i [MAX_TAPS],
  input  logic                               rq_full_i,
  output logic                               rq_wr_o,
  output sglf_pkg::result_t                  result_o,
  output logic                               busy_o
);

  localparam int unsigned IdxBits  = $clog2(MAX_TAPS);
  localparam int unsigned ProdBits = sglf_pkg::CompBits + WEIGHT_BITS;
  localparam int unsigned AccBits  = ProdBits + 5;
  localparam int unsigned RndBits  = AccBits - WEIGHT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                 state_q;
  sglf_pkg::job_t         job_q;
  logic [4:0]             i_q, len, reach, age;
  logic                   use_tap;
  logic [ProdBits-1:0]    prod_d [3];
  logic [ProdBits-1:0]    prod_q [3];
  logic [AccBits-1:0]     acc_q [3];
  logic [AccBits-1:0]     rnd [3];
  logic [sglf_pkg::CompBits-1:0] sat [3];
  logic [sglf_pkg::PixelBits-1:0] px, cpx;
  logic [WEIGHT_BITS-1:0] wt;

  assign len     = {half_width_i, 1'b1};
  assign reach   = 5'(job_q.offset) + 5'(half_width_i);
  assign age     = reach - i_q;
  assign use_tap = (i_q < len) && (i_q <= reach) && (age < job_q.count)
                   && ({1'b0, age} < 6'(MAX_TAPS)) && ({1'b0, i_q} < 6'(MAX_TAPS));
  assign px      = window_i[IdxBits'(age)];
  assign wt      = taps_i[IdxBits'(i_q)];
  assign cpx     = window_i[IdxBits'(job_q.offset)];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_d[c] = use_tap ? ProdBits'(px[c*8 +: 8]) * ProdBits'(wt) : '0;
      rnd[c]    = acc_q[c] + (AccBits'(1) << (WEIGHT_BITS - 1));
      sat[c]    = (rnd[c][AccBits-1:WEIGHT_BITS] > RndBits'(255)) ? 8'hFF
                  : rnd[c][WEIGHT_BITS +: 8];
    end
  end

  assign jq_rd_o         = (state_q == ST_IDLE) && !jq_empty_i;
  assign rq_wr_o         = (state_q == ST_EMIT) && !rq_full_i;
  assign busy_o          = (state_q != ST_IDLE);
  assign result_o.red    = sat[0];
  assign result_o.green  = sat[1];
  assign result_o.blue   = sat[2];
  assign result_o.alpha  = ({1'b0, job_q.offset} < 5'(MAX_TAPS)) ? cpx[31:24] : '0;
  assign result_o.done   = job_q.last;

  always_ff @(posedge clk_i) begin
    if (jq_rd_o) begin
      job_q <= job_i;
    end
    if (state_q == ST_IDLE) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c]  <= '0;
        prod_q[c] <= '0;
      end
    end else if (state_q == ST_MAC) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c]  <= acc_q[c] + AccBits'(prod_q[c]);
        prod_q[c] <= prod_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          if (jq_rd_o) begin
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          i_q <= i_q + 1'b1;
          if (i_q == len) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (rq_wr_o) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/separable_gaussian_line_filter_unit.sv
// Top level of the separable Gaussian line filter.
// Uses sglf_pkg, sglf_front, sglf_back and sglf_fifo.
//
// Input channel: a word is taken on a rising edge with push high and full low.
// A load word writes one tap weight; a pixel word enters the line window and
// causes up to sixteen results, one for each centre that becomes complete.
// Result channel: while empty is low the oldest result is on the output
// ports; it is taken on a rising edge with pop high.
// Configuration: half_width is written through cfg_valid_i and cfg_ready_o;
// the user must write it only while the block is idle, and the block itself
// does not enforce this; cfg_ready_o is always high. A load word does not
// hold full high. A pixel word holds full high until all its results sit in
// the result queue; they are computed one at a time in the single
// multiply-accumulate engine.
// Reset clears the tap store, the window, the line count and both queues,
// and sets half_width to 1. When the receiver stalls, the result queue fills,
// the engine waits and full stays high; no result is lost.
module separable_gaussian_line_filter_unit #(
  parameter int unsigned MAX_TAPS    = sglf_pkg::MaxTapsDefault,
  parameter int unsigned WEIGHT_BITS = sglf_pkg::WeightBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sglf_pkg::HalfWidthBits-1:0] cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation_i,
  input  logic [sglf_pkg::TapIndexBits-1:0]  tap_index_i,
  input  logic [sglf_pkg::TapWeightBits-1:0] tap_weight_i,
  input  logic [7:0]                       in_red_i,
  input  logic [7:0]                       in_green_i,
  input  logic [7:0]                       in_blue_i,
  input  logic [7:0]                       in_alpha_i,
  input  logic                             line_end_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       out_red_o,
  output logic [7:0]                       out_green_o,
  output logic [7:0]                       out_blue_o,
  output logic [7:0]                       out_alpha_o,
  output logic                             line_done_o
);

  localparam int unsigned JobBits = $bits(sglf_pkg::job_t);
  localparam int unsigned ResBits = $bits(sglf_pkg::result_t);

  logic [sglf_pkg::HalfWidthBits-1:0] hw_q;
  logic [sglf_pkg::PixelBits-1:0]     window [MAX_TAPS];
  logic [WEIGHT_BITS-1:0]             taps [MAX_TAPS];
  logic                               busy, back_busy, accept;
  logic                               jq_wr, jq_rd, jq_full, jq_empty;
  logic                               rq_wr, rq_full;
  sglf_pkg::job_t                     job_in, job_out;
  sglf_pkg::result_t                  res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign full        = busy;
  assign accept      = push && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= sglf_pkg::HalfWidthReset;
    end else if (cfg_valid_i) begin
      hw_q <= cfg_data_i;
    end
  end

  sglf_front #(.MAX_TAPS(MAX_TAPS), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_width_i (hw_q),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .tap_index_i  (tap_index_i),
    .tap_weight_i (tap_weight_i),
    .pixel_i      ({in_alpha_i, in_blue_i, in_green_i, in_red_i}),
    .line_end_i   (line_end_i),
    .jq_full_i    (jq_full),
    .jq_empty_i   (jq_empty),
    .back_busy_i  (back_busy),
    .jq_wr_o      (jq_wr),
    .job_o        (job_in),
    .busy_o       (busy),
    .window_o     (window),
    .taps_o       (taps)
  );

  sglf_fifo #(.WIDTH(JobBits), .DEPTH(2)) u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (jq_wr),
    .wdata_i (job_in),
    .rd_i    (jq_rd),
    .rdata_o (job_out),
    .full_o  (jq_full),
    .empty_o (jq_empty)
  );

  sglf_back #(.MAX_TAPS(MAX_TAPS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_width_i (hw_q),
    .jq_empty_i   (jq_empty),
    .job_i        (job_out),
    .jq_rd_o      (jq_rd),
    .window_i     (window),
    .taps_i       (taps),
    .rq_full_i    (rq_full),
    .rq_wr_o      (rq_wr),
    .result_o     (res_in),
    .busy_o       (back_busy)
  );

  sglf_fifo #(.WIDTH(ResBits), .DEPTH(4)) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rq_wr),
    .wdata_i (res_in),
    .rd_i    (pop),
    .rdata_o (res_out),
    .full_o  (rq_full),
    .empty_o (empty)
  );

  assign out_red_o   = res_out.red;
  assign out_green_o = res_out.green;
  assign out_blue_o  = res_out.blue;
  assign out_alpha_o = res_out.alpha;
  assign line_done_o = res_out.done;

endmodule

FILE: src/sglf_checker.sv
// Port-level checks for the separable Gaussian line filter.
// Uses sglf_pkg; bound to separable_gaussian_line_filter_unit below.
module sglf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       operation_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_red_o,
  input logic       line_done_o
);

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && (operation_i == sglf_pkg::OP_LOAD) && empty) |=> empty)
    else $error("A load word produced a result.");

  a_pixel_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && (operation_i == sglf_pkg::OP_PIXEL)) |=> full)
    else $error("Input was not held busy after a pixel word.");

  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_red_o) && $stable(line_done_o)))
    else $error("Waiting result changed before it was taken.");

endmodule

bind separable_gaussian_line_filter_unit sglf_checker u_sglf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .operation_i (operation_i),
  .empty       (empty),
  .pop         (pop),
  .out_red_o   (out_red_o),
  .line_done_o (line_done_o)
);

FILE: dv/testbench.sv
// Self-checking testbench for separable_gaussian_line_filter_unit.
// Drives tap loads and pixel lines through the push/full queue interface and
// checks every result word against a built-in line filter predictor. Uses sglf_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned Taps = sglf_pkg::MaxTapsDefault;
  localparam int unsigned WBits = sglf_pkg::WeightBitsDefault;
  localparam int unsigned WatchLimit = 200000;

  typedef struct packed {
    logic [3:0]  hw;
    logic        cfg;
    logic        op;
    logic [4:0]  idx;
    logic [15:0] weight;
    logic [7:0]  r, g, b, a;
    logic        last;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sglf_pkg::HalfWidthBits-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic operation_i = 1'b0;
  logic [sglf_pkg::TapIndexBits-1:0] tap_index_i = '0;
  logic [sglf_pkg::TapWeightBits-1:0] tap_weight_i = '0;
  logic [7:0] in_red_i = '0, in_green_i = '0, in_blue_i = '0, in_alpha_i = '0;
  logic line_end_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic line_done_o;

  separable_gaussian_line_filter_unit dut (.*);

  word_t pending_words[$];
  sglf_pkg::result_t expected_pixels[$];
  logic [31:0] window[Taps];
  logic [WBits-1:0] weights[Taps];
  int unsigned line_count;
  int unsigned half_width;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit timed_out = 1'b0;
  bit cfg_busy = 1'b0;
  bit stimulus_done = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] round_clip(logic [63:0] acc);
    logic [63:0] v;
    v = (acc + (64'd1 << (WBits - 1))) >> WBits;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic sglf_pkg::result_t filtered_pixel(int unsigned offs, int unsigned cnt,
                                                       bit last);
    logic [63:0] sr, sg, sb;
    int unsigned reach, age;
    sglf_pkg::result_t res;
    sr = 0; sg = 0; sb = 0;
    reach = offs + half_width;
    for (int unsigned i = 0; i < 2 * half_width + 1; i++) begin
      if (i > reach) continue;
      age = reach - i;
      if (age >= cnt || age >= Taps || i >= Taps) continue;
      sr += window[age][7:0] * weights[i];
      sg += window[age][15:8] * weights[i];
      sb += window[age][23:16] * weights[i];
    end
    res.red = round_clip(sr);
    res.green = round_clip(sg);
    res.blue = round_clip(sb);
    res.alpha = (offs < Taps) ? window[offs][31:24] : 8'd0;
    res.done = last;
    return res;
  endfunction

  task automatic predict_word(word_t w);
    int unsigned lo, offs;
    if (w.op == sglf_pkg::OP_LOAD) begin
      if (w.idx < Taps) weights[w.idx] = w.weight;
      return;
    end
    for (int i = Taps - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = {w.a, w.b, w.g, w.r};
    if (line_count < 31) line_count++;
    lo = w.last ? 0 : half_width;
    offs = half_width;
    forever begin
      if (offs < line_count) expected_pixels.push_back(filtered_pixel(offs, line_count,
                                                       w.last && offs == 0));
      if (offs == lo) break;
      offs--;
    end
    if (w.last) line_count = 0;
  endtask

  function automatic word_t tap_word(int unsigned idx, int unsigned weight);
    word_t w;
    w = '0;
    w.op = sglf_pkg::OP_LOAD;
    w.idx = 5'(idx);
    w.weight = 16'(weight);
    w.r = 8'($urandom); w.g = 8'($urandom); w.b = 8'($urandom); w.a = 8'($urandom);
    w.last = 1'($urandom);
    return w;
  endfunction

  function automatic word_t pixel_word(bit last);
    word_t w;
    w = '0;
    w.op = sglf_pkg::OP_PIXEL;
    w.idx = 5'($urandom);
    w.weight = 16'($urandom);
    w.r = 8'($urandom); w.g = 8'($urandom); w.b = 8'($urandom); w.a = 8'($urandom);
    w.last = last;
    return w;
  endfunction

  function automatic word_t config_word(int unsigned hw);
    word_t w;
    w = '0;
    w.cfg = 1'b1;
    w.hw = 4'(hw);
    return w;
  endfunction

  task automatic queue_kernel(int unsigned hw, bit extreme);
    for (int unsigned i = 0; i < 2 * hw + 1; i++)
      pending_words.push_back(tap_word(i, extreme ? 16'hFFFF : $urandom_range(0, 65535 / (hw + 1))));
  endtask

  task automatic queue_line(int unsigned len);
    for (int unsigned i = 1; i <= len; i++) pending_words.push_back(pixel_word(i == len));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
        cfg_busy = 1'b0;
      end else if (push && !full) begin
        push <= 1'b0;
      end else if (!push && !cfg_valid_i && !cfg_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0 && !pending_words[0].cfg) begin
          word_t w;
          w = pending_words.pop_front();
          predict_word(w);
          operation_i <= w.op;
          tap_index_i <= w.idx;
          tap_weight_i <= w.weight;
          in_red_i <= w.r; in_green_i <= w.g; in_blue_i <= w.b; in_alpha_i <= w.a;
          line_end_i <= w.last;
          push <= 1'b1;
          send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                     (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 2));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    sglf_pkg::result_t got, want;
    if (rst_ni) begin
      if (pop && !empty) begin
        idle_cycles = 0;
        got = '{out_red_o, out_green_o, out_blue_o, out_alpha_o, line_done_o};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end else if (push && !full) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (hold_off > 0) begin
        hold_off--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        recv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                   (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 2));
      end
      if (idle_cycles >= WatchLimit) timed_out = 1'b1;
    end
  end

  task automatic apply_config(int unsigned hw);
    wait (pending_words.size() == 0 && !push);
    wait (expected_pixels.size() == 0);
    repeat (2 * 31 * 16 + 50) @(posedge clk_i);
    half_width = hw;
    cfg_busy = 1'b1;
    @(posedge clk_i);
    cfg_data_i <= 4'(hw);
    cfg_valid_i <= 1'b1;
    wait (!cfg_busy);
  endtask

  initial begin
    int unsigned hw_list[6];
    int unsigned items;
    hw_list = '{0, 15, 2, 7, 1, 4};
    for (int i = 0; i < Taps; i++) begin
      window[i] = '0;
      weights[i] = '0;
    end
    line_count = 0;
    half_width = int'(sglf_pkg::HalfWidthReset);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset kernel is all zero; then extreme weights saturate, a bad index is ignored.
    queue_line(2);
    queue_kernel(1, 1'b1);
    pending_words.push_back(tap_word(31, 16'h1234));
    pending_words.push_back(tap_word(30, 16'h0000));
    queue_line(1);
    queue_line(3);
    pending_words.push_back(pixel_word(1'b0));
    pending_words.push_back(pixel_word(1'b0));
    queue_line(1);
    items = 14;

    foreach (hw_list[p]) begin
      apply_config(hw_list[p]);
      queue_kernel(hw_list[p], p == 1);
      items += 2 * hw_list[p] + 1;
      if (p == 1) begin
        queue_line(33);
        items += 33;
        hold_off = 2000;
      end
      while (items < 75 * (p + 1)) begin
        int unsigned len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 35) : $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
          pending_words.push_back(tap_word($urandom_range(0, 31), $urandom));
          items++;
        end
        queue_line(len);
        items += len;
      end
    end
    pending_words.push_back(tap_word(5'h15, 16'hAAAA));
    pending_words.push_back(tap_word(5'h0A, 16'h5555));
    queue_line(4);
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    wait ((pending_words.size() == 0 && !push && expected_pixels.size() == 0) || timed_out);
    if (!timed_out) begin
      repeat (200) @(posedge clk_i);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
        $display("testbench: clean");
      end else begin
        $display("testbench: errors");
      end
      $finish;
    end
  end

  initial begin
    wait (timed_out);
    $display("testbench: errors");
    $finish;
  end
endmodule
